// ===== rtl/bgrm_pkg.sv =====
`default_nettype none

package bgrm_pkg;

   // field widths
   localparam int MV_BITS      = 14;
   localparam int RAIL_BITS    = 15;
   localparam int PCT_BITS     = 7;
   localparam int RUN_BITS     = 3;
   localparam int HB_BITS      = 32;
   localparam int CSR_IDX_BITS = 3;
   localparam int CSR_DAT_BITS = 32;

   // time base, worked in 4-bit digits
   localparam int TIME_BITS   = 48;
   localparam int DIGIT_BITS  = 4;
   localparam int TIME_DIGITS = (TIME_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
   localparam int PAD_BITS    = TIME_DIGITS * DIGIT_BITS;
   localparam int TCNT_BITS   = $clog2(TIME_DIGITS + 1);
   localparam logic [PAD_BITS-1:0] PAD_MASK = PAD_BITS'({TIME_BITS{1'b1}});

   // percent divider
   localparam int REM_BITS = 21;
   localparam int QUO_BITS = 8;
   localparam int DCNT_BITS = 4;
   localparam logic [DCNT_BITS-1:0] DIV_STEPS = DCNT_BITS'(QUO_BITS + 1);

   localparam logic [RAIL_BITS-1:0] LOAD_OFFSET_MV = RAIL_BITS'(50);
   localparam logic [PCT_BITS-1:0]  FULL_PERCENT   = PCT_BITS'(100);
   localparam logic [RUN_BITS-1:0]  RUN_MAX        = RUN_BITS'(7);

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] REG_CHARGE_THRESHOLD = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_CHARGE_LOW       = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_CHARGE_HIGH      = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_DISCHARGE_LOW    = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] REG_DISCHARGE_HIGH   = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] REG_CRITICAL_MV      = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] REG_CRITICAL_NEEDED  = 3'd6;
   localparam logic [CSR_IDX_BITS-1:0] REG_HEARTBEAT        = 3'd7;

   // register reset values
   localparam logic [MV_BITS-1:0]  RST_CHARGE_THRESHOLD = MV_BITS'(4000);
   localparam logic [MV_BITS-1:0]  RST_CHARGE_LOW       = MV_BITS'(4200);
   localparam logic [MV_BITS-1:0]  RST_CHARGE_HIGH      = MV_BITS'(4660);
   localparam logic [MV_BITS-1:0]  RST_DISCHARGE_LOW    = MV_BITS'(2950);
   localparam logic [MV_BITS-1:0]  RST_DISCHARGE_HIGH   = MV_BITS'(3670);
   localparam logic [MV_BITS-1:0]  RST_CRITICAL_MV      = MV_BITS'(2950);
   localparam logic [RUN_BITS-1:0] RST_CRITICAL_NEEDED  = RUN_BITS'(5);
   localparam logic [HB_BITS-1:0]  RST_HEARTBEAT        = HB_BITS'(60 * 1000);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LAUNCH,
      ST_WAIT,
      ST_COMMIT
   } state_type;

   typedef struct packed {
      logic                done;
      logic [PCT_BITS-1:0] pct;
   } div_result_type;

   typedef struct packed {
      logic done;
      logic expired;
   } tmr_result_type;

endpackage

`default_nettype wire

// ===== rtl/bgrm_divider.sv =====
`default_nettype none

// Rail to percent: (rail - lo) * 100 / (hi - lo), saturated to 0..100.
// One multiply step by shift-add, then one quotient bit per cycle.
module bgrm_divider
   import bgrm_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [RAIL_BITS-1:0] rail,
   input  wire logic [MV_BITS-1:0]   lo,
   input  wire logic [MV_BITS-1:0]   hi,
   output div_result_type            result
);

   logic [DCNT_BITS-1:0] cnt_ff, cnt_in;
   logic                 done_ff, done_in;
   logic                 zero_ff, zero_in;
   logic [RAIL_BITS-1:0] diff_ff, diff_in;
   logic [REM_BITS-1:0]  rem_ff, rem_in;
   logic [REM_BITS-1:0]  span_sh_ff, span_sh_in;
   logic [QUO_BITS-1:0]  quo_ff, quo_in;
   logic [MV_BITS-1:0]   span;
   logic                 ge;

   assign span = hi - lo;
   assign ge   = rem_ff >= span_sh_ff;

   // step control
   always_comb begin
      cnt_in     = cnt_ff;
      done_in    = 1'b0;
      zero_in    = zero_ff;
      diff_in    = diff_ff;
      rem_in     = rem_ff;
      span_sh_in = span_sh_ff;
      quo_in     = quo_ff;
      if (start) begin
         zero_in    = (hi <= lo) || (rail <= {1'b0, lo});
         diff_in    = rail - {1'b0, lo};
         span_sh_in = {span, (QUO_BITS - 1)'(0)};
         quo_in     = '0;
         cnt_in     = DIV_STEPS;
      end else if (cnt_ff != '0) begin
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == DCNT_BITS'(1));
         if (cnt_ff == DIV_STEPS) begin
            // times 100 = 64 + 32 + 4
            rem_in = REM_BITS'({diff_ff, 6'b0}) + REM_BITS'({diff_ff, 5'b0})
                   + REM_BITS'({diff_ff, 2'b0});
         end else begin
            if (ge) begin
               rem_in = rem_ff - span_sh_ff;
            end
            quo_in     = {quo_ff[QUO_BITS-2:0], ge};
            span_sh_in = span_sh_ff >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      zero_ff    <= zero_in;
      diff_ff    <= diff_in;
      rem_ff     <= rem_in;
      span_sh_ff <= span_sh_in;
      quo_ff     <= quo_in;
   end

   // saturate: top quotient bit means at least 128
   always_comb begin
      result.done = done_ff;
      if (zero_ff) begin
         result.pct = '0;
      end else if (quo_ff[QUO_BITS-1] || (quo_ff[QUO_BITS-2:0] > FULL_PERCENT)) begin
         result.pct = FULL_PERCENT;
      end else begin
         result.pct = quo_ff[QUO_BITS-2:0];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/bgrm_timer.sv =====
`default_nettype none

// Heartbeat check: (now - sent) mod 2^TIME_BITS >= heartbeat, one 4-bit
// digit per cycle, LSB first, with a running borrow and a running compare.
module bgrm_timer
   import bgrm_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [TIME_BITS-1:0] now,
   input  wire logic [TIME_BITS-1:0] sent,
   input  wire logic [HB_BITS-1:0]   heartbeat,
   output tmr_result_type            result
);

   logic [TCNT_BITS-1:0]  cnt_ff, cnt_in;
   logic                  done_ff, done_in;
   logic [PAD_BITS-1:0]   now_sh_ff, now_sh_in;
   logic [PAD_BITS-1:0]   sent_sh_ff, sent_sh_in;
   logic [PAD_BITS-1:0]   hb_sh_ff, hb_sh_in;
   logic [PAD_BITS-1:0]   mask_sh_ff, mask_sh_in;
   logic                  borrow_ff, borrow_in;
   logic                  ge_ff, ge_in;
   logic [DIGIT_BITS:0]   dsub;
   logic [DIGIT_BITS-1:0] ddig;
   logic [DIGIT_BITS-1:0] hdig;

   // current digit of the difference, padding bits forced to zero
   assign dsub = {1'b0, now_sh_ff[DIGIT_BITS-1:0]} - {1'b0, sent_sh_ff[DIGIT_BITS-1:0]}
               - (DIGIT_BITS + 1)'(borrow_ff);
   assign ddig = dsub[DIGIT_BITS-1:0] & mask_sh_ff[DIGIT_BITS-1:0];
   assign hdig = hb_sh_ff[DIGIT_BITS-1:0];

   always_comb begin
      cnt_in     = cnt_ff;
      done_in    = 1'b0;
      now_sh_in  = now_sh_ff;
      sent_sh_in = sent_sh_ff;
      hb_sh_in   = hb_sh_ff;
      mask_sh_in = mask_sh_ff;
      borrow_in  = borrow_ff;
      ge_in      = ge_ff;
      if (start) begin
         now_sh_in  = PAD_BITS'(now);
         sent_sh_in = PAD_BITS'(sent);
         hb_sh_in   = PAD_BITS'(heartbeat);
         mask_sh_in = PAD_MASK;
         borrow_in  = 1'b0;
         ge_in      = 1'b1;
         cnt_in     = TCNT_BITS'(TIME_DIGITS);
      end else if (cnt_ff != '0) begin
         cnt_in     = cnt_ff - 1'b1;
         done_in    = (cnt_ff == TCNT_BITS'(1));
         now_sh_in  = now_sh_ff >> DIGIT_BITS;
         sent_sh_in = sent_sh_ff >> DIGIT_BITS;
         hb_sh_in   = hb_sh_ff >> DIGIT_BITS;
         mask_sh_in = mask_sh_ff >> DIGIT_BITS;
         borrow_in  = dsub[DIGIT_BITS];
         // a higher digit that differs decides the compare
         if (ddig != hdig) begin
            ge_in = ddig > hdig;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      now_sh_ff  <= now_sh_in;
      sent_sh_ff <= sent_sh_in;
      hb_sh_ff   <= hb_sh_in;
      mask_sh_ff <= mask_sh_in;
      borrow_ff  <= borrow_in;
      ge_ff      <= ge_in;
   end

   assign result.done    = done_ff;
   assign result.expired = ge_ff;

endmodule

`default_nettype wire

// ===== rtl/battery_gauge_ratchet_monitor.sv =====
`default_nettype none

// Channel  Direction  Transfer when          Payload
// req_     in         req_valid & req_ready  battery_mv, sleeping, now_ms
// rsp_     out        rsp_valid & rsp_ready  rail_mv, charging, percent,
//                                            report_due, shutdown
// csr_     in         csr_we                 csr_index, csr_wdata
//
// One sample at a time: accept, launch, one step per time digit of the heartbeat
// subtract, done capture, hand-off to commit and the commit itself. The bit-serial
// percent divider runs alongside the subtract.
// Synchronous active-high reset restores register defaults and clears state.
// A held result stalls the commit step; no new sample is taken until it commits.
module battery_gauge_ratchet_monitor
   import bgrm_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output      logic                    req_ready,
   input  wire logic [MV_BITS-1:0]      req_battery_mv,
   input  wire logic                    req_sleeping,
   input  wire logic [TIME_BITS-1:0]    req_now_ms,
   output      logic                    rsp_valid,
   input  wire logic                    rsp_ready,
   output      logic [RAIL_BITS-1:0]    rsp_rail_mv,
   output      logic                    rsp_charging,
   output      logic [PCT_BITS-1:0]     rsp_percent,
   output      logic                    rsp_report_due,
   output      logic                    rsp_shutdown,
   input  wire logic                    csr_we,
   input  wire logic [CSR_IDX_BITS-1:0] csr_index,
   input  wire logic [CSR_DAT_BITS-1:0] csr_wdata
);

   // configuration registers
   logic [MV_BITS-1:0]  chg_thr_ff, chg_lo_ff, chg_hi_ff;
   logic [MV_BITS-1:0]  dis_lo_ff, dis_hi_ff, crit_mv_ff;
   logic [RUN_BITS-1:0] crit_need_ff;
   logic [HB_BITS-1:0]  heartbeat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         chg_thr_ff   <= RST_CHARGE_THRESHOLD;
         chg_lo_ff    <= RST_CHARGE_LOW;
         chg_hi_ff    <= RST_CHARGE_HIGH;
         dis_lo_ff    <= RST_DISCHARGE_LOW;
         dis_hi_ff    <= RST_DISCHARGE_HIGH;
         crit_mv_ff   <= RST_CRITICAL_MV;
         crit_need_ff <= RST_CRITICAL_NEEDED;
         heartbeat_ff <= RST_HEARTBEAT;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_CHARGE_THRESHOLD: chg_thr_ff   <= csr_wdata[MV_BITS-1:0];
            REG_CHARGE_LOW:       chg_lo_ff    <= csr_wdata[MV_BITS-1:0];
            REG_CHARGE_HIGH:      chg_hi_ff    <= csr_wdata[MV_BITS-1:0];
            REG_DISCHARGE_LOW:    dis_lo_ff    <= csr_wdata[MV_BITS-1:0];
            REG_DISCHARGE_HIGH:   dis_hi_ff    <= csr_wdata[MV_BITS-1:0];
            REG_CRITICAL_MV:      crit_mv_ff   <= csr_wdata[MV_BITS-1:0];
            REG_CRITICAL_NEEDED:  crit_need_ff <= csr_wdata[RUN_BITS-1:0];
            REG_HEARTBEAT:        heartbeat_ff <= csr_wdata[HB_BITS-1:0];
            default: ;
         endcase
      end
   end

   // sample front end
   state_type            state_ff, state_in;
   logic [RAIL_BITS-1:0] rail_ff, rail_in;
   logic                 chg_ff, chg_in;
   logic [TIME_BITS-1:0] now_ff, now_in;
   logic                 req_fire;
   logic [RAIL_BITS-1:0] rail_new;

   assign rail_new = {1'b0, req_battery_mv} + (req_sleeping ? '0 : LOAD_OFFSET_MV);
   assign req_fire = req_valid && req_ready;

   // gauge state
   logic [PCT_BITS-1:0]  shown_ff, shown_in;
   logic                 shown_vld_ff, shown_vld_in;
   logic                 was_chg_ff, was_chg_in;
   logic [PCT_BITS-1:0]  sent_pct_ff, sent_pct_in;
   logic                 sent_vld_ff, sent_vld_in;
   logic [TIME_BITS-1:0] sent_time_ff, sent_time_in;
   logic [RUN_BITS-1:0]  low_run_ff, low_run_in;
   logic                 div_seen_ff, div_seen_in;
   logic                 tmr_seen_ff, tmr_seen_in;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RAIL_BITS-1:0] rsp_rail_ff, rsp_rail_in;
   logic                 rsp_chg_ff, rsp_chg_in;
   logic [PCT_BITS-1:0]  rsp_pct_ff, rsp_pct_in;
   logic                 rsp_send_ff, rsp_send_in;
   logic                 rsp_shut_ff, rsp_shut_in;

   // serial units
   logic                 launch;
   logic [MV_BITS-1:0]   curve_lo, curve_hi;
   div_result_type       div_res;
   tmr_result_type       tmr_res;

   assign curve_lo = chg_ff ? chg_lo_ff : dis_lo_ff;
   assign curve_hi = chg_ff ? chg_hi_ff : dis_hi_ff;

   bgrm_divider u_divider (
      .clock  (clock),
      .reset  (reset),
      .start  (launch),
      .rail   (rail_ff),
      .lo     (curve_lo),
      .hi     (curve_hi),
      .result (div_res)
   );

   bgrm_timer u_timer (
      .clock     (clock),
      .reset     (reset),
      .start     (launch),
      .now       (now_ff),
      .sent      (sent_time_ff),
      .heartbeat (heartbeat_ff),
      .result    (tmr_res)
   );

   // commit arithmetic
   logic                 out_free;
   logic                 critical;
   logic [PCT_BITS-1:0]  shown_new;
   logic [RUN_BITS-1:0]  run_new;
   logic                 send_new;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign critical = !chg_ff && (rail_ff != '0) && (rail_ff < {1'b0, crit_mv_ff});

   always_comb begin
      if (!shown_vld_ff || (chg_ff != was_chg_ff)) begin
         shown_new = div_res.pct;
      end else if (chg_ff) begin
         shown_new = (div_res.pct > shown_ff) ? div_res.pct : shown_ff;
      end else begin
         shown_new = (div_res.pct < shown_ff) ? div_res.pct : shown_ff;
      end
      if (!critical) begin
         run_new = '0;
      end else if (low_run_ff < RUN_MAX) begin
         run_new = low_run_ff + 1'b1;
      end else begin
         run_new = low_run_ff;
      end
      send_new = !sent_vld_ff || (shown_new != sent_pct_ff) || tmr_res.expired;
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      req_ready    = 1'b0;
      launch       = 1'b0;
      rail_in      = rail_ff;
      chg_in       = chg_ff;
      now_in       = now_ff;
      shown_in     = shown_ff;
      shown_vld_in = shown_vld_ff;
      was_chg_in   = was_chg_ff;
      sent_pct_in  = sent_pct_ff;
      sent_vld_in  = sent_vld_ff;
      sent_time_in = sent_time_ff;
      low_run_in   = low_run_ff;
      div_seen_in  = div_seen_ff || div_res.done;
      tmr_seen_in  = tmr_seen_ff || tmr_res.done;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_rail_in  = rsp_rail_ff;
      rsp_chg_in   = rsp_chg_ff;
      rsp_pct_in   = rsp_pct_ff;
      rsp_send_in  = rsp_send_ff;
      rsp_shut_in  = rsp_shut_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_fire) begin
               rail_in  = rail_new;
               chg_in   = rail_new >= {1'b0, chg_thr_ff};
               now_in   = req_now_ms;
               state_in = ST_LAUNCH;
            end
         end
         ST_LAUNCH: begin
            launch      = 1'b1;
            div_seen_in = 1'b0;
            tmr_seen_in = 1'b0;
            state_in    = ST_WAIT;
         end
         ST_WAIT: begin
            if (div_seen_ff && tmr_seen_ff) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            if (out_free) begin
               shown_in     = shown_new;
               shown_vld_in = 1'b1;
               was_chg_in   = chg_ff;
               low_run_in   = run_new;
               if (send_new) begin
                  sent_pct_in  = shown_new;
                  sent_vld_in  = 1'b1;
                  sent_time_in = now_ff;
               end
               rsp_valid_in = 1'b1;
               rsp_rail_in  = rail_ff;
               rsp_chg_in   = chg_ff;
               rsp_pct_in   = shown_new;
               rsp_send_in  = send_new;
               rsp_shut_in  = critical && (run_new >= crit_need_ff);
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         shown_vld_ff <= 1'b0;
         was_chg_ff   <= 1'b0;
         sent_vld_ff  <= 1'b0;
         sent_time_ff <= '0;
         low_run_ff   <= '0;
         div_seen_ff  <= 1'b0;
         tmr_seen_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         shown_vld_ff <= shown_vld_in;
         was_chg_ff   <= was_chg_in;
         sent_vld_ff  <= sent_vld_in;
         sent_time_ff <= sent_time_in;
         low_run_ff   <= low_run_in;
         div_seen_ff  <= div_seen_in;
         tmr_seen_ff  <= tmr_seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rail_ff     <= rail_in;
      chg_ff      <= chg_in;
      now_ff      <= now_in;
      shown_ff    <= shown_in;
      sent_pct_ff <= sent_pct_in;
      rsp_rail_ff <= rsp_rail_in;
      rsp_chg_ff  <= rsp_chg_in;
      rsp_pct_ff  <= rsp_pct_in;
      rsp_send_ff <= rsp_send_in;
      rsp_shut_ff <= rsp_shut_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_rail_mv    = rsp_rail_ff;
   assign rsp_charging   = rsp_chg_ff;
   assign rsp_percent    = rsp_pct_ff;
   assign rsp_report_due = rsp_send_ff;
   assign rsp_shutdown   = rsp_shut_ff;

endmodule

`default_nettype wire

// ===== bench/battery_gauge_ratchet_monitor_tb.sv =====
`default_nettype none

module battery_gauge_ratchet_monitor_tb;
   import bgrm_pkg::*;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES = 40;
   localparam int MV_MAX = 16383;

   // one transfer on the result channel
   typedef struct {
      logic [RAIL_BITS-1:0] rail_mv;
      logic                 charging;
      logic [PCT_BITS-1:0]  percent;
      logic                 report_due;
      logic                 shutdown;
   } gauge_status_type;

   // voltage neighborhoods that random sequences dwell in
   typedef enum int {
      MV_NEAR_THRESHOLD,
      MV_DISCHARGE_CURVE,
      MV_CHARGE_CURVE,
      MV_NEAR_CRITICAL,
      MV_BELOW_CRITICAL,
      MV_ANYWHERE,
      MV_EDGES,
      MV_DRIFT
   } mv_region_type;

   // receiver stall patterns
   typedef enum int {
      RX_STEADY,
      RX_COIN,
      RX_RHYTHM,
      RX_SPARSE
   } rx_mode_type;

   // Gauge predictor plus the queue of statuses it still owes.
   class gauge_scoreboard_type;
      logic [MV_BITS-1:0]   threshold_mv, chg_lo_mv, chg_hi_mv, dis_lo_mv, dis_hi_mv, crit_mv;
      logic [RUN_BITS-1:0]  crit_needed;
      logic [HB_BITS-1:0]   heartbeat;
      logic [PCT_BITS-1:0]  shown_pct, sent_pct;
      bit                   shown_valid, sent_valid, was_charging;
      logic [TIME_BITS-1:0] sent_time;
      logic [RUN_BITS-1:0]  low_run;
      gauge_status_type     owed_q[$];
      int                   n_samples, n_statuses, n_sends, n_shutdowns, n_charging, errors;

      function new();
         threshold_mv = RST_CHARGE_THRESHOLD;
         chg_lo_mv    = RST_CHARGE_LOW;
         chg_hi_mv    = RST_CHARGE_HIGH;
         dis_lo_mv    = RST_DISCHARGE_LOW;
         dis_hi_mv    = RST_DISCHARGE_HIGH;
         crit_mv      = RST_CRITICAL_MV;
         crit_needed  = RST_CRITICAL_NEEDED;
         heartbeat    = RST_HEARTBEAT;
         shown_pct    = '0;
         sent_pct     = '0;
         shown_valid  = 0;
         sent_valid   = 0;
         was_charging = 0;
         sent_time    = '0;
         low_run      = '0;
      endfunction

      function void set_reg(logic [CSR_IDX_BITS-1:0] idx, logic [CSR_DAT_BITS-1:0] data);
         case (idx)
            REG_CHARGE_THRESHOLD: threshold_mv = data[MV_BITS-1:0];
            REG_CHARGE_LOW:       chg_lo_mv    = data[MV_BITS-1:0];
            REG_CHARGE_HIGH:      chg_hi_mv    = data[MV_BITS-1:0];
            REG_DISCHARGE_LOW:    dis_lo_mv    = data[MV_BITS-1:0];
            REG_DISCHARGE_HIGH:   dis_hi_mv    = data[MV_BITS-1:0];
            REG_CRITICAL_MV:      crit_mv      = data[MV_BITS-1:0];
            REG_CRITICAL_NEEDED:  crit_needed  = data[RUN_BITS-1:0];
            REG_HEARTBEAT:        heartbeat    = data[HB_BITS-1:0];
            default: ;
         endcase
      endfunction

      // linear map onto 0..100, saturating at both ends
      function int unsigned curve_percent(int unsigned rail, int unsigned lo, int unsigned hi);
         int unsigned q;
         if (hi <= lo || rail <= lo) return 0;
         q = ((rail - lo) * 100) / (hi - lo);
         return (q > 100) ? 100 : q;
      endfunction

      // accepted sample: advance the gauge and queue the status it owes
      function void note_sample(logic [MV_BITS-1:0] batt, logic sleeping,
                                logic [TIME_BITS-1:0] now_ms);
         gauge_status_type     st;
         logic [RAIL_BITS-1:0] rail;
         logic [TIME_BITS-1:0] elapsed;
         logic [PCT_BITS-1:0]  pct;
         bit                   chg;
         rail = RAIL_BITS'(batt) + (sleeping ? RAIL_BITS'(0) : LOAD_OFFSET_MV);
         chg  = rail >= RAIL_BITS'(threshold_mv);
         if (chg) pct = PCT_BITS'(curve_percent(rail, chg_lo_mv, chg_hi_mv));
         else     pct = PCT_BITS'(curve_percent(rail, dis_lo_mv, dis_hi_mv));

         // ratchet: rise only while charging, fall only while discharging
         if (!shown_valid || chg != was_charging) begin
            shown_pct   = pct;
            shown_valid = 1;
         end else if (chg) begin
            if (pct > shown_pct) shown_pct = pct;
         end else begin
            if (pct < shown_pct) shown_pct = pct;
         end
         was_charging = chg;

         // critical-low run counter, saturating
         st.shutdown = 0;
         if (!chg && rail != 0 && rail < RAIL_BITS'(crit_mv)) begin
            if (low_run != RUN_MAX) low_run = low_run + 1'b1;
            st.shutdown = low_run >= crit_needed;
         end else begin
            low_run = '0;
         end

         // send pacing, timer wraps at the time width
         elapsed = now_ms - sent_time;
         st.report_due = !sent_valid || shown_pct != sent_pct ||
                         elapsed >= TIME_BITS'(heartbeat);
         if (st.report_due) begin
            sent_pct   = shown_pct;
            sent_valid = 1;
            sent_time  = now_ms;
         end

         st.rail_mv  = rail;
         st.charging = chg;
         st.percent  = shown_pct;
         owed_q.push_back(st);
         n_samples++;
      endfunction

      function void check_result(gauge_status_type got);
         gauge_status_type exp_st;
         n_statuses++;
         if (owed_q.size() == 0) begin
            $error("status transfer with nothing outstanding (rail_mv %0d)", got.rail_mv);
            errors++;
            return;
         end
         exp_st = owed_q.pop_front();
         if (got.rail_mv !== exp_st.rail_mv) begin
            $error("rail_mv: expected %0d, actual %0d", exp_st.rail_mv, got.rail_mv);
            errors++;
         end
         if (got.charging !== exp_st.charging) begin
            $error("charging: expected %0d, actual %0d", exp_st.charging, got.charging);
            errors++;
         end
         if (got.percent !== exp_st.percent) begin
            $error("percent: expected %0d, actual %0d", exp_st.percent, got.percent);
            errors++;
         end
         if (got.report_due !== exp_st.report_due) begin
            $error("report_due: expected %0d, actual %0d",
                   exp_st.report_due, got.report_due);
            errors++;
         end
         if (got.shutdown !== exp_st.shutdown) begin
            $error("shutdown: expected %0d, actual %0d", exp_st.shutdown, got.shutdown);
            errors++;
         end
         if (exp_st.report_due) n_sends++;
         if (exp_st.shutdown) n_shutdowns++;
         if (exp_st.charging) n_charging++;
      endfunction

      function int pending();
         return owed_q.size();
      endfunction
   endclass

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   logic [MV_BITS-1:0]      req_battery_mv;
   logic                    req_sleeping;
   logic [TIME_BITS-1:0]    req_now_ms;
   logic                    rsp_valid;
   logic                    rsp_ready;
   logic [RAIL_BITS-1:0]    rsp_rail_mv;
   logic                    rsp_charging;
   logic [PCT_BITS-1:0]     rsp_percent;
   logic                    rsp_report_due;
   logic                    rsp_shutdown;
   logic                    csr_we;
   logic [CSR_IDX_BITS-1:0] csr_index;
   logic [CSR_DAT_BITS-1:0] csr_wdata;

   gauge_scoreboard_type gauge_sb = new();
   bit                   rsp_hold_req;
   int                   n_holds;
   int                   n_settings;
   int                   cycle_count;
   logic [TIME_BITS-1:0] clock_ms;
   logic [MV_BITS-1:0]   last_mv;

   battery_gauge_ratchet_monitor dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_battery_mv  (req_battery_mv),
      .req_sleeping    (req_sleeping),
      .req_now_ms      (req_now_ms),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_rail_mv     (rsp_rail_mv),
      .rsp_charging    (rsp_charging),
      .rsp_percent     (rsp_percent),
      .rsp_report_due  (rsp_report_due),
      .rsp_shutdown    (rsp_shutdown),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   // clock
   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d statuses outstanding",
                  cycle_count, gauge_sb.pending());
         $display("Simulation FAILED");
         $finish;
      end
   end

   // status monitor
   always @(posedge clock) begin
      gauge_status_type got;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         got.rail_mv    = rsp_rail_mv;
         got.charging   = rsp_charging;
         got.percent    = rsp_percent;
         got.report_due = rsp_report_due;
         got.shutdown   = rsp_shutdown;
         gauge_sb.check_result(got);
      end
   end

   // receiver: shifting stall patterns, plus a long hold-off on request
   initial begin
      rx_mode_type mode;
      int          span;
      rsp_ready = 0;
      forever begin
         if (rsp_hold_req) begin
            rsp_hold_req = 0;
            rsp_ready    = 0;
            n_holds++;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         mode = rx_mode_type'($urandom_range(0, 3));
         span = $urandom_range(10, 80);
         for (int k = 0; k < span && !rsp_hold_req; k++) begin
            case (mode)
               RX_STEADY: rsp_ready = 1;
               RX_COIN:   rsp_ready = $urandom_range(0, 1);
               RX_RHYTHM: rsp_ready = (k % 4) != 3;
               RX_SPARSE: rsp_ready = $urandom_range(0, 9) < 3;
               default:   rsp_ready = 1;
            endcase
            @(negedge clock);
         end
      end
   end

   function automatic logic [MV_BITS-1:0] clamp_mv(int v);
      if (v < 0) return '0;
      if (v > MV_MAX) return MV_BITS'(MV_MAX);
      return MV_BITS'(v);
   endfunction

   // uniform pick over [a, b] widened by pad, either bound order
   function automatic logic [MV_BITS-1:0] mv_between(int a, int b, int pad);
      int lo, hi;
      lo = ((a < b) ? a : b) - pad;
      hi = ((a < b) ? b : a) + pad;
      return clamp_mv(lo + int'($urandom_range(0, hi - lo)));
   endfunction

   function automatic logic [MV_BITS-1:0] pick_mv(mv_region_type region, logic sleeping);
      int load;
      load = sleeping ? 0 : 50;
      case (region)
         MV_NEAR_THRESHOLD:
            return mv_between(gauge_sb.threshold_mv - load, gauge_sb.threshold_mv - load, 60);
         MV_DISCHARGE_CURVE:
            return mv_between(gauge_sb.dis_lo_mv - load, gauge_sb.dis_hi_mv - load, 30);
         MV_CHARGE_CURVE:
            return mv_between(gauge_sb.chg_lo_mv - load, gauge_sb.chg_hi_mv - load, 30);
         MV_NEAR_CRITICAL:
            return mv_between(gauge_sb.crit_mv - load, gauge_sb.crit_mv - load, 3);
         MV_BELOW_CRITICAL:
            return clamp_mv(int'(gauge_sb.crit_mv) - 1 - load - int'($urandom_range(0, 300)));
         MV_ANYWHERE:
            return MV_BITS'($urandom_range(0, MV_MAX));
         MV_EDGES: begin
            case ($urandom_range(0, 5))
               0: return '0;
               1: return MV_BITS'(1);
               2: return MV_BITS'(MV_MAX);
               3: return MV_BITS'(MV_MAX - 1);
               4: return MV_BITS'(14'h2000);
               default: return MV_BITS'(14'h1FFF);
            endcase
         end
         default:
            return clamp_mv(int'(last_mv) + int'($urandom_range(0, 40)) - 20);
      endcase
   endfunction

   // sample timestamps: mostly steady seconds, some jumps, heartbeat edges and wraps
   function automatic logic [TIME_BITS-1:0] next_now();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70)
         clock_ms = clock_ms + TIME_BITS'($urandom_range(200, 3000));
      else if (r < 77)
         ;
      else if (r < 86)
         clock_ms = gauge_sb.sent_time + TIME_BITS'(gauge_sb.heartbeat)
                    + TIME_BITS'($urandom_range(0, 2)) - TIME_BITS'(1);
      else if (r < 92)
         clock_ms = clock_ms + TIME_BITS'($urandom);
      else if (r < 96)
         clock_ms = {16'($urandom), $urandom};
      else
         clock_ms = {TIME_BITS{1'b1}} - TIME_BITS'($urandom_range(0, 5000));
      return clock_ms;
   endfunction

   // offer one sample and hold it until the transfer; returns at a falling edge
   task automatic drive_sample(input logic [MV_BITS-1:0] mv, input logic sleeping,
                               input logic [TIME_BITS-1:0] now_ms);
      req_battery_mv = mv;
      req_sleeping   = sleeping;
      req_now_ms     = now_ms;
      req_valid      = 1;
      do @(posedge clock); while (req_ready !== 1'b1);
      gauge_sb.note_sample(mv, sleeping, now_ms);
      last_mv = mv;
      @(negedge clock);
   endtask

   // drop valid and wait for every owed status
   task automatic drain_gauge();
      req_valid = 0;
      while (gauge_sb.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] idx, input logic [31:0] value);
      logic [CSR_DAT_BITS-1:0] data;
      // junk above the field width must be dropped by the block
      if (idx == REG_HEARTBEAT) data = value;
      else if (idx == REG_CRITICAL_NEEDED) data = ($urandom & 32'hFFFF_FFF8) | (value & 32'h7);
      else data = ($urandom & 32'hFFFF_C000) | (value & 32'h3FFF);
      csr_index = idx;
      csr_wdata = data;
      csr_we    = 1;
      @(negedge clock);
      csr_we = 0;
      gauge_sb.set_reg(idx, data);
   endtask

   task automatic program_gauge(input int th, input int clo, input int chi, input int dlo,
                                input int dhi, input int crit, input int need,
                                input logic [31:0] hb);
      drain_gauge();
      write_reg(REG_CHARGE_THRESHOLD, th);
      write_reg(REG_CHARGE_LOW, clo);
      write_reg(REG_CHARGE_HIGH, chi);
      write_reg(REG_DISCHARGE_LOW, dlo);
      write_reg(REG_DISCHARGE_HIGH, dhi);
      write_reg(REG_CRITICAL_MV, crit);
      write_reg(REG_CRITICAL_NEEDED, need);
      write_reg(REG_HEARTBEAT, hb);
      n_settings++;
   endtask

   // realistic settings drawn around the defaults
   task automatic program_plausible();
      program_gauge($urandom_range(3800, 4200), $urandom_range(4100, 4300),
                    $urandom_range(4500, 4800), $urandom_range(2800, 3100),
                    $urandom_range(3500, 3800), $urandom_range(2800, 3100),
                    $urandom_range(1, 7), $urandom_range(1000, 100000));
   endtask

   // random sequences dwelling in one voltage neighborhood, sent in bursts
   task automatic run_random(input int count);
      mv_region_type      region;
      int                 seq_left, burst_left;
      logic               sleeping;
      logic [MV_BITS-1:0] mv;
      seq_left   = 0;
      burst_left = $urandom_range(1, 30);
      for (int n = 0; n < count; n++) begin
         if (seq_left == 0) begin
            region   = mv_region_type'($urandom_range(0, 7));
            seq_left = $urandom_range(2, 14);
         end
         sleeping = $urandom_range(0, 1);
         mv = pick_mv(region, sleeping);
         drive_sample(mv, sleeping, next_now());
         seq_left--;
         burst_left--;
         if (burst_left == 0) begin
            req_valid = 0;
            repeat ($urandom_range(1, 16)) @(negedge clock);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 120)
                                                     : $urandom_range(1, 30);
         end
      end
      req_valid = 0;
   endtask

   // main sequence
   initial begin
      reset          = 1;
      req_valid      = 0;
      req_battery_mv = '0;
      req_sleeping   = 0;
      req_now_ms     = '0;
      csr_we         = 0;
      csr_index      = '0;
      csr_wdata      = '0;
      rsp_hold_req   = 0;
      clock_ms       = '0;
      last_mv        = '0;
      repeat (10) @(negedge clock);
      reset = 0;

      // directed at reset settings
      drive_sample(14'd3600, 0, 48'd0);      // first sample loads and sends
      drive_sample(14'd3600, 1, 48'd1000);   // lower reading ratchets down
      drive_sample(14'd3660, 0, 48'd2000);   // above the curve, held down
      drive_sample(14'd4500, 1, 48'd3000);   // flip to charging reloads
      drive_sample(14'd4100, 1, 48'd4000);   // below charge curve, held up
      drive_sample(14'h3FFF, 0, 48'd5000);   // widest rail
      drive_sample(14'd3950, 0, 48'd6000);   // rail exactly at threshold
      drive_sample(14'd3999, 1, 48'd7000);   // back to discharging
      drive_sample(14'd0, 1, 48'd8000);      // zero rail is not critical
      drive_sample(14'd0, 0, 48'd8500);      // load offset only
      for (int k = 0; k < 7; k++)            // critical run, shutdown then saturation
         drive_sample(14'd2800, 1, 48'(9000 + 1000 * k));
      drive_sample(14'd2900, 0, 48'd16000);  // rail equal to critical clears the run
      drive_sample(14'd2899, 0, 48'd17000);
      drive_sample(14'd2899, 0, gauge_sb.sent_time + 48'(RST_HEARTBEAT) - 48'd1);
      drive_sample(14'd2899, 0, gauge_sb.sent_time + 48'(RST_HEARTBEAT));
      drive_sample(14'd2899, 0, {TIME_BITS{1'b1}});  // timer wrap
      drive_sample(14'd2899, 0, 48'd10);
      clock_ms = 48'd20;
      run_random(200);

      // plausible settings, two with a long receiver hold-off
      program_plausible();
      rsp_hold_req = 1;
      run_random(270);
      program_plausible();
      run_random(270);
      program_plausible();
      rsp_hold_req = 1;
      run_random(270);

      // all zero: always charging, empty spans, every sample sends
      program_gauge(0, 0, 0, 0, 0, 0, 0, 32'd0);
      run_random(140);
      // charging only near full scale, critical but for zero rail, full-scale curves
      program_gauge(MV_MAX, 0, MV_MAX, 0, MV_MAX, MV_MAX, 0, 32'd0);
      run_random(140);
      // everything at its maximum
      program_gauge(MV_MAX, MV_MAX, MV_MAX, MV_MAX, MV_MAX, MV_MAX, 7, 32'hFFFF_FFFF);
      run_random(140);
      // inverted curves
      program_gauge(3000, 4600, 4200, 3600, 2900, 3200, 7, 32'd1);
      run_random(140);
      // one-millivolt curves
      program_gauge(4000, 4300, 4301, 3300, 3301, 3100, 1, 32'd2500);
      run_random(140);

      drain_gauge();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (gauge_sb.pending() != 0) begin
         $error("%0d statuses never arrived", gauge_sb.pending());
         gauge_sb.errors++;
      end

      $display("Ran %0d samples under %0d register settings plus reset values, %0d hold-offs.",
               gauge_sb.n_samples, n_settings, n_holds);
      $display("Checked %0d statuses: %0d sends, %0d shutdowns, %0d while charging.",
               gauge_sb.n_statuses, gauge_sb.n_sends, gauge_sb.n_shutdowns,
               gauge_sb.n_charging);
      if (gauge_sb.errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
